// ===== src/msbm_pkg.sv =====
// ----------------------------------------------------------------------------
// msbm_pkg: shared definitions for the multi-signature byte matcher
// Sizes of the signature store, window and scan counter, function codes and
// the command bundle that drives the recent-byte history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msbm_pkg;

  // Store and scan dimensions.
  localparam int NUM_SIGS     = 16;
  localparam int MAX_SIG_LEN  = 32;
  localparam int MAX_SCAN_LEN = 16384;
  localparam int RESULT_LIMIT = 16;

  // Derived widths.
  localparam int BYTE_W = 8;
  localparam int ROW_W  = BYTE_W * MAX_SIG_LEN;
  localparam int SLOT_W = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
  localparam int CNT_W  = $clog2(NUM_SIGS + 1);
  localparam int POS_W  = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
  localparam int LEN_W  = $clog2(MAX_SIG_LEN + 1);
  localparam int SEEN_W = $clog2(MAX_SCAN_LEN + 1);
  localparam int RC_W   = $clog2(RESULT_LIMIT + 1);

  // Fixed field widths of the ports.
  localparam int FUNC_W   = 2;
  localparam int SEL_W    = 4;
  localparam int BPOS_W   = 5;
  localparam int SLEN_W   = 6;
  localparam int IDX_W    = 4;
  localparam int OFF_W    = 14;
  localparam int MLEN_W   = 6;

  // Function codes of an input transfer.
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LEN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCAN = 2'd2;

  // Command to the recent-byte history.
  typedef struct packed {
    logic              shift;
    logic              clear;
    logic [BYTE_W-1:0] data;
  } hist_cmd_t;

endpackage

`default_nettype wire

// ===== src/multi_signature_byte_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_signature_byte_matcher: exact multi-signature byte scanner
// Load items write signature bytes, length items set a slot's length (0
// disables it), and scan items push one data byte into a window of the newest
// bytes. For each scan byte the enabled signatures that end on that byte are
// reported in ascending slot order with index, start offset and length; the
// final report of a byte carries last. A scan item is paced by the single
// compare unit, which takes one signature row per cycle from the signature
// RAM unless a result is held by a stalled output, and no new item is taken
// until the current one is done; a load is a read-modify-write of one row of
// that RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_signature_byte_matcher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [msbm_pkg::FUNC_W-1:0] func,
  input  logic [msbm_pkg::SEL_W-1:0]  sig_select,
  input  logic [msbm_pkg::BPOS_W-1:0] byte_pos,
  input  logic [msbm_pkg::BYTE_W-1:0] byte_value,
  input  logic [msbm_pkg::SLEN_W-1:0] sig_len,
  input  logic                        end_of_scan,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [msbm_pkg::IDX_W-1:0]  match_index,
  output logic [msbm_pkg::OFF_W-1:0]  start_offset,
  output logic [msbm_pkg::MLEN_W-1:0] match_length,
  output logic                        last
);

  import msbm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t state;

  // Latched load item and end-of-scan flag.
  logic [SLOT_W-1:0] sel_q;
  logic [POS_W-1:0]  pos_q;
  logic [BYTE_W-1:0] val_q;
  logic              eos_q;

  // Scan sequencer.
  logic [CNT_W-1:0]  rd_slot;
  logic [SLOT_W-1:0] cmp_slot;
  logic              cmp_valid;
  logic [RC_W-1:0]   res_count;

  // Result held back until it is known whether it is the final one.
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_index;
  logic [OFF_W-1:0]  pend_off;
  logic [MLEN_W-1:0] pend_len;

  logic [LEN_W-1:0]  sig_lengths [NUM_SIGS];

  logic [SLOT_W-1:0] ram_addr;
  logic              ram_we;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;

  hist_cmd_t         hist_cmd;
  logic [ROW_W-1:0]  window;
  logic [SEEN_W-1:0] seen;
  logic              full;

  logic [LEN_W-1:0]  cmp_len;
  logic              cmp_match;
  logic [SEEN_W-1:0] cmp_off;

  logic              accept;
  logic              sel_ok;
  logic              pos_ok;
  logic              out_free;
  logic              match_now;
  logic              hold;
  logic              scan_done;
  logic              flush_done;
  logic              push;
  logic              push_last;

  msbm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SIGS)
  ) u_sig_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  msbm_hist u_hist (
    .clk    (clk),
    .rst    (rst),
    .cmd    (hist_cmd),
    .window (window),
    .seen   (seen),
    .full   (full)
  );

  msbm_cmp u_cmp (
    .row    (ram_rdata),
    .window (window),
    .len    (cmp_len),
    .seen   (seen),
    .match  (cmp_match)
  );

  // Input handshake and item checks.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign sel_ok   = (int'(sig_select) < NUM_SIGS);
  assign pos_ok   = (int'(byte_pos) < MAX_SIG_LEN);

  // Compare-stage qualification and the output slot.
  always_comb begin
    cmp_len    = sig_lengths[cmp_slot];
    cmp_off    = seen - SEEN_W'(cmp_len);
    out_free   = !out_valid || !out_stall;
    match_now  = (state == S_SCAN) && cmp_valid && cmp_match &&
                 (res_count < RC_W'(RESULT_LIMIT));
    hold       = match_now && pend_valid && !out_free;
    scan_done  = (state == S_SCAN) && !hold && (rd_slot == CNT_W'(NUM_SIGS));
    flush_done = (state == S_FLUSH) && (!pend_valid || out_free);
    push       = ((state == S_SCAN) && match_now && pend_valid && !hold) ||
                 ((state == S_FLUSH) && pend_valid && out_free);
    push_last  = (state == S_FLUSH);
  end

  // Signature RAM port: read-modify-write for loads, row sweep for scans.
  always_comb begin
    ram_addr  = '0;
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    unique case (state)
      S_LD_RD: begin
        ram_addr = sel_q;
      end
      S_LD_WR: begin
        ram_addr = sel_q;
        ram_we   = 1'b1;
        for (int b = 0; b < MAX_SIG_LEN; b++) begin
          if (pos_q == POS_W'(b)) begin
            ram_wdata[BYTE_W*b +: BYTE_W] = val_q;
          end
        end
      end
      S_SCAN: begin
        ram_addr = hold ? cmp_slot : rd_slot[SLOT_W-1:0];
      end
      default: begin
        ram_addr = '0;
      end
    endcase
  end

  // History commands: shift on an accepted scan byte, clear at end of scan.
  always_comb begin
    hist_cmd.data  = byte_value;
    hist_cmd.shift = accept && (func == FUNC_SCAN) && !full;
    hist_cmd.clear = (accept && (func == FUNC_SCAN) && full && end_of_scan) ||
                     (flush_done && eos_q);
  end

  // Signature length table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SIGS; s++) begin
        sig_lengths[s] <= '0;
      end
    end else if (accept && (func == FUNC_LEN) && sel_ok) begin
      if (int'(sig_len) > MAX_SIG_LEN) begin
        sig_lengths[SLOT_W'(sig_select)] <= LEN_W'(MAX_SIG_LEN);
      end else begin
        sig_lengths[SLOT_W'(sig_select)] <= LEN_W'(sig_len);
      end
    end
  end

  // Sequencer, pending result and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_slot    <= '0;
      cmp_valid  <= 1'b0;
      res_count  <= '0;
      eos_q      <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Output register: load a result or retire the one taken.
      if (push) begin
        out_valid    <= 1'b1;
        match_index  <= pend_index;
        start_offset <= pend_off;
        match_length <= pend_len;
        last         <= push_last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (func)
              FUNC_LOAD: begin
                if (sel_ok && pos_ok) begin
                  sel_q <= SLOT_W'(sig_select);
                  pos_q <= POS_W'(byte_pos);
                  val_q <= byte_value;
                  state <= S_LD_RD;
                end
              end
              FUNC_SCAN: begin
                if (!full) begin
                  rd_slot   <= '0;
                  cmp_valid <= 1'b0;
                  res_count <= '0;
                  eos_q     <= end_of_scan;
                  state     <= S_SCAN;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LD_RD: begin
          state <= S_LD_WR;
        end
        S_LD_WR: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (!hold) begin
            if (match_now) begin
              pend_valid <= 1'b1;
              pend_index <= IDX_W'(cmp_slot);
              pend_off   <= cmp_off[OFF_W-1:0];
              pend_len   <= MLEN_W'(cmp_len);
              res_count  <= res_count + RC_W'(1);
            end
            if (scan_done) begin
              cmp_valid <= 1'b0;
              state     <= S_FLUSH;
            end else begin
              cmp_slot  <= rd_slot[SLOT_W-1:0];
              cmp_valid <= 1'b1;
              rd_slot   <= rd_slot + CNT_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (flush_done) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // No result is left pending once the block is ready again.
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !pend_valid)
    else $error("pending result left behind at end of scan");

  // The per-byte result count stays within its limit.
  assert property (@(posedge clk) disable iff (rst) res_count <= RC_W'(RESULT_LIMIT))
    else $error("too many results for one scan byte");

  // A row write always follows the read of the same load.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LD_WR) |-> ($past(state) == S_LD_RD))
    else $error("signature row written without a prior read");

  // A held compare keeps its slot so that the reread row lines up.
  assert property (@(posedge clk) disable iff (rst)
    hold |=> (cmp_valid && $stable(cmp_slot)))
    else $error("compare slot moved during an output hold");

endmodule

`default_nettype wire

// ===== src/msbm_ram.sv =====
// ----------------------------------------------------------------------------
// msbm_ram: generic single-port RAM
// One access per cycle, a write and a read of the same address; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                            wdata,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== src/msbm_cmp.sv =====
// ----------------------------------------------------------------------------
// msbm_cmp: shared signature compare unit
// Lines up one signature row against the newest window bytes and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msbm_cmp (
  input  logic [msbm_pkg::ROW_W-1:0]  row,
  input  logic [msbm_pkg::ROW_W-1:0]  window,
  input  logic [msbm_pkg::LEN_W-1:0]  len,
  input  logic [msbm_pkg::SEEN_W-1:0] seen,
  output logic                        match
);

  import msbm_pkg::*;

  logic [ROW_W-1:0]       rev;
  logic [ROW_W-1:0]       aligned;
  logic [LEN_W-1:0]       diff;
  logic [POS_W-1:0]       shamt;
  logic [MAX_SIG_LEN-1:0] eq;

  // Reverse the row so that signature byte len-1 lands on the newest byte
  // after a right shift by the unused part of the row.
  always_comb begin
    for (int j = 0; j < MAX_SIG_LEN; j++) begin
      rev[BYTE_W*j +: BYTE_W] = row[BYTE_W*(MAX_SIG_LEN-1-j) +: BYTE_W];
    end
    diff    = LEN_W'(MAX_SIG_LEN) - len;
    shamt   = diff[POS_W-1:0];
    aligned = rev >> {shamt, 3'b000};
  end

  // Byte compares; positions beyond the length always agree.
  always_comb begin
    for (int j = 0; j < MAX_SIG_LEN; j++) begin
      eq[j] = (LEN_W'(j) >= len) ||
              (aligned[BYTE_W*j +: BYTE_W] == window[BYTE_W*j +: BYTE_W]);
    end
    match = (&eq) && (len != '0) && (SEEN_W'(len) <= seen);
  end

endmodule

`default_nettype wire

// ===== src/msbm_hist.sv =====
// ----------------------------------------------------------------------------
// msbm_hist: recent-byte window and scan offset counter
// Shifts scan bytes into a window of the newest bytes and counts them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msbm_hist (
  input  logic                        clk,
  input  logic                        rst,
  input  msbm_pkg::hist_cmd_t         cmd,
  output logic [msbm_pkg::ROW_W-1:0]  window,
  output logic [msbm_pkg::SEEN_W-1:0] seen,
  output logic                        full
);

  import msbm_pkg::*;

  logic [BYTE_W-1:0] win [MAX_SIG_LEN];

  // Window shift register, newest byte at position zero.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int j = 0; j < MAX_SIG_LEN; j++) begin
        win[j] <= '0;
      end
      seen <= '0;
    end else if (cmd.shift) begin
      win[0] <= cmd.data;
      for (int j = 1; j < MAX_SIG_LEN; j++) begin
        win[j] <= win[j-1];
      end
      seen <= seen + SEEN_W'(1);
    end
  end

  // Flattened view for the compare unit.
  always_comb begin
    for (int j = 0; j < MAX_SIG_LEN; j++) begin
      window[BYTE_W*j +: BYTE_W] = win[j];
    end
  end

  assign full = (seen == SEEN_W'(MAX_SCAN_LEN));

  // The offset counter stops at the scan limit.
  assert property (@(posedge clk) disable iff (rst) seen <= SEEN_W'(MAX_SCAN_LEN))
    else $error("scan offset counter passed the scan limit");

  // A clear empties the counter.
  assert property (@(posedge clk) disable iff (rst) cmd.clear |=> (seen == '0))
    else $error("scan offset counter not cleared");

endmodule

`default_nettype wire
